// ===== rtl/vln_pkg.sv =====
// vln_pkg: shared types and constants of the vector length / normalize block
// used by vln_ctrl, vln_dp and vec2_length_normalize; depends on nothing
`timescale 1ns / 1ps

package vln_pkg;

  // field widths of one beat
  localparam int COMP_W = 32;
  localparam int MAG_W  = 32;
  localparam int UNIT_W = 16;

  // square root yields one result bit per step, divide one quotient bit per step
  localparam int ROOT_STEPS = MAG_W;
  localparam int DIV_STEPS  = UNIT_W;
  localparam int CNT_W      = $clog2(ROOT_STEPS);

  // opcodes
  localparam logic OP_LEN_ONLY  = 1'b0;
  localparam logic OP_NORMALIZE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture a new input beat
    logic sq_x;       // square of |x|
    logic sq_y;       // square of |y|
    logic sum;        // add squares, start the root
    logic root_step;  // one digit of the square root
    logic div_load;   // start a divide
    logic div_sel_y;  // divide |y| instead of |x|
    logic div_step;   // one quotient bit
    logic save_x;     // keep the finished x quotient
    logic finish;     // load the result registers
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sum_zero;   // both components are zero
    logic len_only;   // opcode asks for the length only
  } dp_stat_t;

endpackage

// ===== rtl/vln_ctrl.sv =====
// vln_ctrl: sequencer for the vector length / normalize block
// depends on vln_pkg; drives vln_dp through dp_cmd_t, reads dp_stat_t
`timescale 1ns / 1ps

module vln_ctrl
  import vln_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     valid_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SUM,
    S_ROOT,
    S_DIVX_LD,
    S_DIVX,
    S_DIVY_LD,
    S_DIVY,
    S_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             valid_q;

  // state, step counter and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_SQX;
          end
        end
        S_SQX: begin
          state_q <= S_SQY;
        end
        S_SQY: begin
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (stat_i.sum_zero) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_ROOT;
            cnt_q   <= CNT_W'(ROOT_STEPS - 1);
          end
        end
        S_ROOT: begin
          if (cnt_q == '0) begin
            state_q <= stat_i.len_only ? S_FIN : S_DIVX_LD;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_DIVX_LD: begin
          state_q <= S_DIVX;
          cnt_q   <= CNT_W'(DIV_STEPS - 1);
        end
        S_DIVX: begin
          if (cnt_q == '0) begin
            state_q <= S_DIVY_LD;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_DIVY_LD: begin
          state_q <= S_DIVY;
          cnt_q   <= CNT_W'(DIV_STEPS - 1);
        end
        S_DIVY: begin
          if (cnt_q == '0) begin
            state_q <= S_FIN;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_FIN: begin
          valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && start;
    cmd_o.sq_x      = (state_q == S_SQX);
    cmd_o.sq_y      = (state_q == S_SQY);
    cmd_o.sum       = (state_q == S_SUM);
    cmd_o.root_step = (state_q == S_ROOT);
    cmd_o.div_load  = (state_q == S_DIVX_LD) || (state_q == S_DIVY_LD);
    cmd_o.div_sel_y = (state_q == S_DIVY_LD);
    cmd_o.div_step  = (state_q == S_DIVX) || (state_q == S_DIVY);
    cmd_o.save_x    = (state_q == S_DIVY_LD);
    cmd_o.finish    = (state_q == S_FIN);
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;

endmodule

// ===== rtl/vln_dp.sv =====
// vln_dp: datapath with shared squarer, digit-serial square root and
// bit-serial divider; depends on vln_pkg, commanded by vln_ctrl
`timescale 1ns / 1ps

module vln_dp
  import vln_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic                     opcode_i,
  input  logic signed [COMP_W-1:0] comp_x_i,
  input  logic signed [COMP_W-1:0] comp_y_i,
  output logic        [MAG_W-1:0]  magnitude_o,
  output logic signed [UNIT_W-1:0] unit_x_o,
  output logic signed [UNIT_W-1:0] unit_y_o,
  output logic                     zero_length_o
);

  // quotient to signed unit component, +1.0 clipped to the largest positive code
  function automatic logic [UNIT_W-1:0] sat_unit(input logic [UNIT_W-1:0] q,
                                                 input logic neg);
    logic [UNIT_W-1:0] pos_max;
    pos_max = {1'b0, {(UNIT_W-1){1'b1}}};
    if (neg) begin
      sat_unit = ~q + 1'b1;
    end else if (q > pos_max) begin
      sat_unit = pos_max;
    end else begin
      sat_unit = q;
    end
  endfunction

  logic                 opc_q;
  logic                 negx_q, negy_q;
  logic                 zero_q;
  logic [COMP_W-1:0]    ax_q, ay_q;
  logic [2*COMP_W-1:0]  sqx_q, sqy_q;
  logic [2*COMP_W-1:0]  rad_q;
  logic [MAG_W+1:0]     rem_q;
  logic [MAG_W-1:0]     root_q;
  logic [MAG_W-1:0]     dr_q;
  logic [DIV_STEPS-1:0] dsh_q;
  logic [UNIT_W-1:0]    quo_q;
  logic [UNIT_W-1:0]    ux_q;

  logic [MAG_W-1:0]     out_mag_q;
  logic [UNIT_W-1:0]    out_ux_q, out_uy_q;
  logic                 out_zero_q;

  logic [COMP_W-1:0]    mul_a;
  logic [2*COMP_W-1:0]  prod;
  logic [MAG_W+3:0]     r_shift, r_trial;
  logic                 r_ge;
  logic [MAG_W:0]       d_shift, d_div;
  logic                 d_ge;
  logic [COMP_W-1:0]    dnum;
  logic                 units_off;

  // shared squarer
  assign mul_a = cmd_i.sq_y ? ay_q : ax_q;
  assign prod  = {{COMP_W{1'b0}}, mul_a} * {{COMP_W{1'b0}}, mul_a};

  // root digit: bring down two radicand bits, try (root << 2) | 1
  assign r_shift = {rem_q, rad_q[2*COMP_W-1 -: 2]};
  assign r_trial = {2'b00, root_q, 2'b01};
  assign r_ge    = (r_shift >= r_trial);

  // divide bit: bring down one dividend bit, compare with the length
  assign d_shift = {dr_q, dsh_q[DIV_STEPS-1]};
  assign d_div   = {1'b0, root_q};
  assign d_ge    = (d_shift >= d_div);
  assign dnum    = cmd_i.div_sel_y ? ay_q : ax_q;

  assign units_off = zero_q || (opc_q == OP_LEN_ONLY);

  // input capture and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      opc_q  <= opcode_i;
      negx_q <= comp_x_i[COMP_W-1];
      negy_q <= comp_y_i[COMP_W-1];
      ax_q   <= comp_x_i[COMP_W-1] ? (~comp_x_i + 1'b1) : comp_x_i;
      ay_q   <= comp_y_i[COMP_W-1] ? (~comp_y_i + 1'b1) : comp_y_i;
      zero_q <= (comp_x_i == '0) && (comp_y_i == '0);
    end
    if (cmd_i.sq_x) begin
      sqx_q <= prod;
    end
    if (cmd_i.sq_y) begin
      sqy_q <= prod;
    end
    // square root, one result bit per step
    if (cmd_i.sum) begin
      rad_q  <= sqx_q + sqy_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[2*COMP_W-3:0], 2'b00};
      rem_q  <= r_ge ? (MAG_W+2)'(r_shift - r_trial) : r_shift[MAG_W+1:0];
      root_q <= {root_q[MAG_W-2:0], r_ge};
    end
    // restoring divide of (|c| << 15) by the length, |c| never exceeds it
    if (cmd_i.div_load) begin
      dr_q  <= {1'b0, dnum[COMP_W-1:1]};
      dsh_q <= {dnum[0], {(DIV_STEPS-1){1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dr_q  <= d_ge ? MAG_W'(d_shift - d_div) : d_shift[MAG_W-1:0];
      dsh_q <= {dsh_q[DIV_STEPS-2:0], 1'b0};
      quo_q <= {quo_q[UNIT_W-2:0], d_ge};
    end
    if (cmd_i.save_x) begin
      ux_q <= sat_unit(quo_q, negx_q);
    end
  end

  // result registers, held until the next beat finishes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_mag_q  <= '0;
      out_ux_q   <= '0;
      out_uy_q   <= '0;
      out_zero_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_mag_q  <= zero_q ? '0 : root_q;
      out_ux_q   <= units_off ? '0 : ux_q;
      out_uy_q   <= units_off ? '0 : sat_unit(quo_q, negy_q);
      out_zero_q <= zero_q;
    end
  end

  assign stat_o.sum_zero = zero_q;
  assign stat_o.len_only = (opc_q == OP_LEN_ONLY);

  assign magnitude_o   = out_mag_q;
  assign unit_x_o      = out_ux_q;
  assign unit_y_o      = out_uy_q;
  assign zero_length_o = out_zero_q;

endmodule

// ===== rtl/vec2_length_normalize.sv =====
// vec2_length_normalize: length and unit direction of one 2D fixed-point vector
// depends on vln_pkg, vln_ctrl and vln_dp
//
// channel  | direction | handshake       | payload
// ---------+-----------+-----------------+-----------------------------------------------
// command  | in        | start & !busy   | opcode_i, comp_x_i, comp_y_i
// result   | out       | valid_o strobe  | magnitude_o, unit_x_o, unit_y_o, zero_length_o
//
// one beat at a time: busy covers the squares, the 32-step square root and, with opcode 1,
// two 16-step divides; a zero vector skips the root and the divides
// the result strobe comes in the same cycle that busy falls, and a new beat may start then
// a result stays on the ports until the next one; the receiver cannot stall
// asynchronous active-low reset returns the sequencer to idle with no strobe
`timescale 1ns / 1ps

module vec2_length_normalize
  import vln_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode_i,
  input  logic signed [COMP_W-1:0] comp_x_i,
  input  logic signed [COMP_W-1:0] comp_y_i,
  output logic                     valid_o,
  output logic        [MAG_W-1:0]  magnitude_o,
  output logic signed [UNIT_W-1:0] unit_x_o,
  output logic signed [UNIT_W-1:0] unit_y_o,
  output logic                     zero_length_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  vln_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .valid_o (valid_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // arithmetic
  vln_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .opcode_i      (opcode_i),
    .comp_x_i      (comp_x_i),
    .comp_y_i      (comp_y_i),
    .magnitude_o   (magnitude_o),
    .unit_x_o      (unit_x_o),
    .unit_y_o      (unit_y_o),
    .zero_length_o (zero_length_o)
  );

endmodule
